FILE: hdl/sbls_pkg.sv
// Shared constants and types for the spectrum band level scaler.
// No dependencies; used by every module under hdl/.
package sbls_pkg;

  // Field widths fixed by the interface.
  localparam int SENS_W  = 10;
  localparam int BAND_W  = 3;
  localparam int LEVEL_W = 11;
  localparam int TOTAL_W = 14;

  localparam logic [SENS_W-1:0]  SENS_RESET = 10'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 11'd2046;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 14'd16383;

  // floor(floor(p/100)*20/100) == floor(p/500)
  localparam int LEVEL_DIV = 500;

  // Parameter defaults for the top level.
  localparam int BAND_COUNT_DEF  = 7;
  localparam int CAL_SWEEPS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 10;

  // Per-beat position flags within a sweep.
  typedef struct packed {
    logic first;
    logic last;
  } sbls_tag_t;

endpackage

FILE: hdl/sbls_front.sv
// Input stage: band/sweep sequencing, baseline store and baseline subtract.
// Depends on sbls_pkg.
module sbls_front #(
  parameter int BAND_COUNT  = sbls_pkg::BAND_COUNT_DEF,
  parameter int CAL_SWEEPS  = sbls_pkg::CAL_SWEEPS_DEF,
  parameter int SAMPLE_BITS = sbls_pkg::SAMPLE_BITS_DEF,
  localparam int BW = $clog2(BAND_COUNT)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [SAMPLE_BITS-1:0] up_sample,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [SAMPLE_BITS-1:0] dn_diff,
  output logic [BW-1:0]          dn_band,
  output sbls_pkg::sbls_tag_t    dn_tag
);

  localparam int AW  = SAMPLE_BITS + $clog2(CAL_SWEEPS + 1);   // calibration sum
  localparam int SWW = (CAL_SWEEPS > 1) ? $clog2(CAL_SWEEPS) : 1;
  localparam int SC  = AW + $clog2(CAL_SWEEPS);
  localparam longint unsigned MC_L =
    ((64'd1 << SC) + longint'(CAL_SWEEPS) - 64'd1) / longint'(CAL_SWEEPS);
  localparam logic [AW:0] MC = MC_L[AW:0];

  logic [BW-1:0]  band_cnt_r;
  logic [SWW-1:0] sweep_cnt_r;
  logic           cal_r;

  logic                   s1_v_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [BW-1:0]          s1_band_r;
  logic                   s1_last_r;
  logic                   s1_cal_r;
  logic                   s1_final_r;

  logic [AW-1:0] base_r [BAND_COUNT];

  logic                   s2_v_r;
  logic [SAMPLE_BITS-1:0] s2_diff_r;
  logic [BW-1:0]          s2_band_r;
  sbls_pkg::sbls_tag_t    s2_tag_r;

  logic          s2_rdy, s1_adv, acc, in_last, sweep_end;
  logic [AW-1:0] base_rd, cal_sum, base_nxt, sample_ext;
  logic [2*AW:0] cal_prod;
  logic [SAMPLE_BITS-1:0] diff_nxt;

  assign s2_rdy   = !s2_v_r || dn_ready;
  assign s1_adv   = s1_v_r && s2_rdy;
  assign up_ready = !s1_v_r || s2_rdy;
  assign acc      = up_valid && up_ready;

  assign in_last   = (band_cnt_r == BW'(BAND_COUNT - 1));
  assign sweep_end = (sweep_cnt_r == SWW'(CAL_SWEEPS - 1));

  // Calibration: accumulate; on a band's final sweep divide by CAL_SWEEPS
  // through a reciprocal multiply (exact for AW-bit sums).
  assign base_rd    = base_r[s1_band_r];
  assign sample_ext = AW'(s1_sample_r);
  assign cal_sum    = base_rd + sample_ext;
  assign cal_prod   = (2*AW+1)'(cal_sum) * (2*AW+1)'(MC);
  assign base_nxt   = s1_final_r ? AW'(cal_prod >> SC) : cal_sum;

  assign diff_nxt = (sample_ext > base_rd) ? SAMPLE_BITS'(sample_ext - base_rd)
                                           : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_cnt_r  <= '0;
      sweep_cnt_r <= '0;
      cal_r       <= 1'b1;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        base_r[i] <= '0;
      end
    end else begin
      if (acc) begin
        band_cnt_r <= in_last ? '0 : band_cnt_r + 1'b1;
        if (cal_r && in_last) begin
          if (sweep_end) begin
            cal_r       <= 1'b0;
            sweep_cnt_r <= '0;
          end else begin
            sweep_cnt_r <= sweep_cnt_r + 1'b1;
          end
        end
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv && s1_cal_r) begin
        base_r[s1_band_r] <= base_nxt;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r && !s1_cal_r;
      end
    end
  end

  // Payload, no reset.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_sample_r <= up_sample;
      s1_band_r   <= band_cnt_r;
      s1_last_r   <= in_last;
      s1_cal_r    <= cal_r;
      s1_final_r  <= cal_r && sweep_end;
    end
    if (s2_rdy) begin
      s2_diff_r      <= diff_nxt;
      s2_band_r      <= s1_band_r;
      s2_tag_r.first <= (s1_band_r == '0);
      s2_tag_r.last  <= s1_last_r;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_diff  = s2_diff_r;
  assign dn_band  = s2_band_r;
  assign dn_tag   = s2_tag_r;

endmodule

FILE: hdl/sbls_scale.sv
// Gain stage: diff * sensitivity, then /500 with saturation, two registers.
// Depends on sbls_pkg.
module sbls_scale #(
  parameter int BAND_COUNT  = sbls_pkg::BAND_COUNT_DEF,
  parameter int SAMPLE_BITS = sbls_pkg::SAMPLE_BITS_DEF,
  localparam int BW = $clog2(BAND_COUNT)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sbls_pkg::SENS_W-1:0]  sens,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [SAMPLE_BITS-1:0]       up_diff,
  input  logic [BW-1:0]                up_band,
  input  sbls_pkg::sbls_tag_t          up_tag,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic [sbls_pkg::LEVEL_W-1:0] dn_level,
  output logic [BW-1:0]                dn_band,
  output sbls_pkg::sbls_tag_t          dn_tag
);

  localparam int PW   = SAMPLE_BITS + sbls_pkg::SENS_W;
  localparam int S500 = PW + $clog2(sbls_pkg::LEVEL_DIV);
  localparam longint unsigned M500_L =
    ((64'd1 << S500) + longint'(sbls_pkg::LEVEL_DIV) - 64'd1) /
    longint'(sbls_pkg::LEVEL_DIV);
  localparam logic [PW:0] M500 = M500_L[PW:0];
  localparam int QW = PW + 1 - $clog2(sbls_pkg::LEVEL_DIV);

  logic                s3_v_r;
  logic [PW-1:0]       s3_p_r;
  logic [BW-1:0]       s3_band_r;
  sbls_pkg::sbls_tag_t s3_tag_r;

  logic                         s4_v_r;
  logic [sbls_pkg::LEVEL_W-1:0] s4_level_r;
  logic [BW-1:0]                s4_band_r;
  sbls_pkg::sbls_tag_t          s4_tag_r;

  logic                         s3_rdy, s4_rdy;
  logic [PW-1:0]                p_nxt;
  logic [2*PW:0]                prod500;
  logic [QW-1:0]                q;
  logic [sbls_pkg::LEVEL_W-1:0] level_nxt;

  assign s4_rdy   = !s4_v_r || dn_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign up_ready = s3_rdy;

  assign p_nxt   = PW'(up_diff) * PW'(sens);
  assign prod500 = (2*PW+1)'(s3_p_r) * (2*PW+1)'(M500);
  assign q       = QW'(prod500 >> S500);
  assign level_nxt = (32'(q) > 32'(sbls_pkg::LEVEL_MAX)) ? sbls_pkg::LEVEL_MAX
                                                         : sbls_pkg::LEVEL_W'(q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s3_rdy) begin
        s3_v_r <= up_valid;
      end
      if (s4_rdy) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_p_r    <= p_nxt;
      s3_band_r <= up_band;
      s3_tag_r  <= up_tag;
    end
    if (s4_rdy) begin
      s4_level_r <= level_nxt;
      s4_band_r  <= s3_band_r;
      s4_tag_r   <= s3_tag_r;
    end
  end

  assign dn_valid = s4_v_r;
  assign dn_level = s4_level_r;
  assign dn_band  = s4_band_r;
  assign dn_tag   = s4_tag_r;

endmodule

FILE: hdl/sbls_accum.sv
// Sweep accumulator: running total, average on the last band, output register.
// Depends on sbls_pkg.
module sbls_accum #(
  parameter int BAND_COUNT = sbls_pkg::BAND_COUNT_DEF,
  localparam int BW = $clog2(BAND_COUNT)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic [sbls_pkg::LEVEL_W-1:0] up_level,
  input  logic [BW-1:0]                up_band,
  input  sbls_pkg::sbls_tag_t          up_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbls_pkg::BAND_W-1:0]  out_band,
  output logic [sbls_pkg::LEVEL_W-1:0] out_level,
  output logic [sbls_pkg::TOTAL_W-1:0] out_total_volume,
  output logic [sbls_pkg::LEVEL_W-1:0] out_average_volume,
  output logic                         out_last_band
);

  localparam int TW = sbls_pkg::TOTAL_W;
  localparam int LW = sbls_pkg::LEVEL_W;
  localparam int S7 = TW + $clog2(BAND_COUNT);
  localparam longint unsigned M7_L =
    ((64'd1 << S7) + longint'(BAND_COUNT) - 64'd1) / longint'(BAND_COUNT);
  localparam logic [TW:0] M7 = M7_L[TW:0];

  logic [TW-1:0] total_r;

  logic          s5_v_r;
  logic [LW-1:0] s5_level_r;
  logic [TW-1:0] s5_total_r;
  logic [BW-1:0] s5_band_r;
  logic          s5_last_r;

  logic                         o_v_r;
  logic [sbls_pkg::BAND_W-1:0]  o_band_r;
  logic [LW-1:0]                o_level_r;
  logic [TW-1:0]                o_total_r;
  logic [LW-1:0]                o_avg_r;
  logic                         o_last_r;

  logic          o_rdy, s5_rdy, up_acc;
  logic [TW:0]   sum;
  logic [TW-1:0] total_nxt;
  logic [2*TW:0] prod7;
  logic [LW-1:0] avg_nxt;

  assign o_rdy    = !o_v_r || out_ready;
  assign s5_rdy   = !s5_v_r || o_rdy;
  assign up_ready = s5_rdy;
  assign up_acc   = up_valid && s5_rdy;

  // Running total restarts on band 0, saturates at the field maximum.
  assign sum       = (up_tag.first ? '0 : (TW+1)'(total_r)) + (TW+1)'(up_level);
  assign total_nxt = (sum > (TW+1)'(sbls_pkg::TOTAL_MAX)) ? sbls_pkg::TOTAL_MAX
                                                          : TW'(sum);

  // total / BAND_COUNT by reciprocal multiply
  assign prod7   = (2*TW+1)'(s5_total_r) * (2*TW+1)'(M7);
  assign avg_nxt = s5_last_r ? LW'(prod7 >> S7) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      s5_v_r  <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (up_acc) begin
        total_r <= total_nxt;
      end
      if (s5_rdy) begin
        s5_v_r <= up_valid;
      end
      if (o_rdy) begin
        o_v_r <= s5_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      s5_level_r <= up_level;
      s5_total_r <= total_nxt;
      s5_band_r  <= up_band;
      s5_last_r  <= up_tag.last;
    end
    if (o_rdy) begin
      o_band_r  <= sbls_pkg::BAND_W'(s5_band_r);
      o_level_r <= s5_level_r;
      o_total_r <= s5_total_r;
      o_avg_r   <= avg_nxt;
      o_last_r  <= s5_last_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_band           = o_band_r;
  assign out_level          = o_level_r;
  assign out_total_volume   = o_total_r;
  assign out_average_volume = o_avg_r;
  assign out_last_band      = o_last_r;

endmodule

FILE: hdl/spectrum_band_level_scaler.sv
// Top level of the spectrum band level scaler.
// Depends on sbls_pkg, sbls_front, sbls_scale, sbls_accum.
//
// Usage:
//   Input channel (in_valid/in_ready/in_adc_sample): one converter sample per
//   beat, bands in fixed cyclic order starting at band 0 after reset.
//   Output channel (out_valid/out_ready/out_*): one beat per sample once
//   calibration is done, carrying band index, level, running sweep total and,
//   on the last band, the sweep average (zero on other bands).
//   Config port (cfg_wr_en/cfg_wr_data): sensitivity in hundredths, written
//   in the cycle cfg_wr_en is high; change it only while the block is idle.
// Reset (rst_n low, synchronous): band and sweep counters cleared, baselines
//   zeroed, sensitivity back to 100, pipeline emptied. The first CAL_SWEEPS
//   sweeps are calibration: they are consumed and give no output beat.
// Timing: six-register pipeline (input, subtract, multiply, /500, total,
//   output). One beat per cycle sustained while out_ready stays high;
//   each stage's ready looks only at the stage after it, so bubbles are
//   absorbed and a held output does not block input until all stages are
//   full. With out_ready low the output beat holds.
module spectrum_band_level_scaler #(
  parameter int BAND_COUNT  = sbls_pkg::BAND_COUNT_DEF,
  parameter int CAL_SWEEPS  = sbls_pkg::CAL_SWEEPS_DEF,
  parameter int SAMPLE_BITS = sbls_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [sbls_pkg::SENS_W-1:0]  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [SAMPLE_BITS-1:0]       in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbls_pkg::BAND_W-1:0]  out_band,
  output logic [sbls_pkg::LEVEL_W-1:0] out_level,
  output logic [sbls_pkg::TOTAL_W-1:0] out_total_volume,
  output logic [sbls_pkg::LEVEL_W-1:0] out_average_volume,
  output logic                         out_last_band
);

  localparam int BW = $clog2(BAND_COUNT);

  // Sensitivity register.
  logic [sbls_pkg::SENS_W-1:0] sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= sbls_pkg::SENS_RESET;
    end else if (cfg_wr_en) begin
      sens_r <= cfg_wr_data;
    end
  end

  // front -> scale
  logic                   fs_valid, fs_ready;
  logic [SAMPLE_BITS-1:0] fs_diff;
  logic [BW-1:0]          fs_band;
  sbls_pkg::sbls_tag_t    fs_tag;

  // scale -> accum
  logic                         sa_valid, sa_ready;
  logic [sbls_pkg::LEVEL_W-1:0] sa_level;
  logic [BW-1:0]                sa_band;
  sbls_pkg::sbls_tag_t          sa_tag;

  // Sequencing, calibration and baseline subtract.
  sbls_front #(
    .BAND_COUNT  (BAND_COUNT),
    .CAL_SWEEPS  (CAL_SWEEPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_sample (in_adc_sample),
    .dn_valid  (fs_valid),
    .dn_ready  (fs_ready),
    .dn_diff   (fs_diff),
    .dn_band   (fs_band),
    .dn_tag    (fs_tag)
  );

  // Gain and fixed /500 scaling.
  sbls_scale #(
    .BAND_COUNT  (BAND_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .sens     (sens_r),
    .up_valid (fs_valid),
    .up_ready (fs_ready),
    .up_diff  (fs_diff),
    .up_band  (fs_band),
    .up_tag   (fs_tag),
    .dn_valid (sa_valid),
    .dn_ready (sa_ready),
    .dn_level (sa_level),
    .dn_band  (sa_band),
    .dn_tag   (sa_tag)
  );

  // Sweep total, average and output register.
  sbls_accum #(
    .BAND_COUNT (BAND_COUNT)
  ) u_accum (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (sa_valid),
    .up_ready           (sa_ready),
    .up_level           (sa_level),
    .up_band            (sa_band),
    .up_tag             (sa_tag),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_band           (out_band),
    .out_level          (out_level),
    .out_total_volume   (out_total_volume),
    .out_average_volume (out_average_volume),
    .out_last_band      (out_last_band)
  );

endmodule

FILE: tb/sv/spectrum_band_level_scaler_tb.sv
// Self-checking bench for spectrum_band_level_scaler: calibration, directed and random sweeps.
// Depends on sbls_pkg and the spectrum_band_level_scaler RTL under hdl/.
// Built-in scaler model predicts every output beat; random stalls on both channels.
module spectrum_band_level_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BANDS        = sbls_pkg::BAND_COUNT_DEF;
  localparam int CAL_SWEEPS   = sbls_pkg::CAL_SWEEPS_DEF;
  localparam int SAMPLE_W     = sbls_pkg::SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  // Pipeline is six stages deep; wait a bit longer than that when draining,
  // since calibration beats leave no trace on the output.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS  = 150;
  // ~1300 beats, each at worst the longest send gap plus the longest output
  // stall plus latency, stay well inside this limit; keep a wide margin.
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [sbls_pkg::BAND_W-1:0]  band;
    logic [sbls_pkg::LEVEL_W-1:0] level;
    logic [sbls_pkg::TOTAL_W-1:0] total;
    logic [sbls_pkg::LEVEL_W-1:0] average;
    logic                         is_last;
  } band_result_t;

  logic                         clk                = 1'b0;
  logic                         rst_n              = 1'b0;
  logic                         cfg_wr_en          = 1'b0;
  logic [sbls_pkg::SENS_W-1:0]  cfg_wr_data        = '0;
  logic                         in_valid           = 1'b0;
  logic                         in_ready;
  logic [SAMPLE_W-1:0]          in_adc_sample      = '0;
  logic                         out_valid;
  logic                         out_ready          = 1'b0;
  logic [sbls_pkg::BAND_W-1:0]  out_band;
  logic [sbls_pkg::LEVEL_W-1:0] out_level;
  logic [sbls_pkg::TOTAL_W-1:0] out_total_volume;
  logic [sbls_pkg::LEVEL_W-1:0] out_average_volume;
  logic                         out_last_band;

  spectrum_band_level_scaler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_adc_sample      (in_adc_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_band           (out_band),
    .out_level          (out_level),
    .out_total_volume   (out_total_volume),
    .out_average_volume (out_average_volume),
    .out_last_band      (out_last_band)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Scaler model: mirrors the block's state as seen after reset.
  // baseline[] holds running sums while calibrating, band means after.
  // ---------------------------------------------------------------------
  logic [sbls_pkg::SENS_W-1:0] sens_model = sbls_pkg::SENS_RESET;
  int                band_pos     = 0;
  int                cal_sweeps_done = 0;
  bit                calibrating  = 1'b1;
  int                baseline [BANDS];
  int                sweep_sum    = 0;
  band_result_t      pending_results [$];
  int                error_count  = 0;

  // Pacing knobs; a steady phase runs with no idle cycles on that side.
  bit                in_steady    = 1'b0;
  bit                out_steady   = 1'b0;

  function automatic int scaled_level(int diff);
    int pct;
    int lvl;
    pct = (diff * int'(sens_model)) / 100;
    lvl = (pct * 20) / 100;
    return (lvl > int'(sbls_pkg::LEVEL_MAX)) ? int'(sbls_pkg::LEVEL_MAX) : lvl;
  endfunction

  // Advance the model by one accepted sample; queue a result once calibrated.
  task automatic track_sample(input logic [SAMPLE_W-1:0] sample);
    int           b;
    int           raw;
    int           diff;
    int           lvl;
    bit           sweep_end;
    band_result_t r;
    b         = band_pos;
    raw       = int'(sample);
    sweep_end = (b == BANDS - 1);
    band_pos  = sweep_end ? 0 : b + 1;
    if (calibrating) begin
      baseline[b] += raw;
      if (sweep_end) begin
        cal_sweeps_done++;
        if (cal_sweeps_done >= CAL_SWEEPS) begin
          foreach (baseline[i]) baseline[i] = baseline[i] / CAL_SWEEPS;
          calibrating     = 1'b0;
          cal_sweeps_done = 0;
        end
      end
    end else begin
      diff = (raw > baseline[b]) ? raw - baseline[b] : 0;
      lvl  = scaled_level(diff);
      if (b == 0) sweep_sum = 0;
      sweep_sum += lvl;
      if (sweep_sum > int'(sbls_pkg::TOTAL_MAX)) sweep_sum = int'(sbls_pkg::TOTAL_MAX);
      r.band    = sbls_pkg::BAND_W'(b);
      r.level   = sbls_pkg::LEVEL_W'(lvl);
      r.total   = sbls_pkg::TOTAL_W'(sweep_sum);
      r.average = sbls_pkg::LEVEL_W'(sweep_end ? sweep_sum / BANDS : 0);
      r.is_last = sweep_end;
      pending_results.push_back(r);
    end
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(4, 30));
  endfunction

  // Random sample for the band about to be sent: uniform, rails, and values
  // hugging the band baseline so the clamp at zero gets exercised.
  function automatic int pick_sample();
    int r;
    int v;
    r = int'($urandom_range(0, 99));
    if (r < 8) return SAMPLE_MAX;
    if (r < 15) return 0;
    if (r < 30) begin
      v = baseline[band_pos] + int'($urandom_range(0, 6)) - 3;
      return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    end
    return int'($urandom_range(0, SAMPLE_MAX));
  endfunction

  // ---------------------------------------------------------------------
  // Input driver. Entered just after the previous beat's accepting edge;
  // payload changes on the falling edge, acceptance is seen on the rising
  // edge. in_valid only drops when a gap is actually inserted.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_sample(sample);
  endtask

  // Stop sending, let every predicted beat come out, then cover latency for
  // beats that produce nothing (calibration) before touching the register.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_sensitivity(input logic [sbls_pkg::SENS_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sens_model   = value;
  endtask

  // ---------------------------------------------------------------------
  // Output pacing: out_ready toggles on falling edges with random stalls.
  // ---------------------------------------------------------------------
  initial begin : sink_pacing
    int stall;
    int run;
    @(negedge clk);
    forever begin
      if (out_steady) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        run = int'($urandom_range(1, 12));
        repeat (run) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every accepted output beat against the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    band_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected beat, band %0d level %0d", $time, out_band, out_level);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("band", 16'(want.band), 16'(out_band));
        check_field("level", 16'(want.level), 16'(out_level));
        check_field("total_volume", 16'(want.total), 16'(out_total_volume));
        check_field("average_volume", 16'(want.average), 16'(out_average_volume));
        check_field("last_band", 16'(want.is_last), 16'(out_last_band));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Ten sweeps that set the baselines: band 0 sits at zero so its level can
  // reach full scale, band 6 averages to 1022.x so the mean must round down,
  // band 1 spans the whole range, the rest stay low.
  task automatic test_calibration();
    int s;
    for (int sweep = 0; sweep < CAL_SWEEPS; sweep++) begin
      for (int b = 0; b < BANDS; b++) begin
        case (b)
          0: begin
            s = 0;
          end
          1: begin
            s = int'($urandom_range(0, SAMPLE_MAX));
          end
          BANDS - 1: begin
            s = (sweep == 0) ? SAMPLE_MAX - 6 : SAMPLE_MAX;
          end
          default: begin
            s = int'($urandom_range(0, 300));
          end
        endcase
        send_sample(SAMPLE_W'(s));
      end
    end
    drain_block();
  endtask

  // Edge sweeps: reset sensitivity with samples at, just above and just
  // below the baseline; full gain with full-scale input (level saturates);
  // zero gain.
  task automatic test_directed();
    int s;
    for (int b = 0; b < BANDS; b++) begin
      case (b)
        1: begin
          s = baseline[1];
        end
        2: begin
          s = baseline[2] + 1;
        end
        3: begin
          s = 0;
        end
        5: begin
          s = (baseline[5] > 0) ? baseline[5] - 1 : 0;
        end
        default: begin
          s = SAMPLE_MAX;
        end
      endcase
      send_sample(SAMPLE_W'(s));
    end
    drain_block();

    write_sensitivity({sbls_pkg::SENS_W{1'b1}});
    for (int b = 0; b < BANDS; b++) send_sample(SAMPLE_W'(SAMPLE_MAX));
    drain_block();

    write_sensitivity('0);
    for (int b = 0; b < BANDS; b++) send_sample(SAMPLE_W'(pick_sample()));
    drain_block();
  endtask

  // Random phases, each with its own gain and its own pacing on both sides.
  task automatic test_random();
    int r;
    logic [sbls_pkg::SENS_W-1:0] sens;
    for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
      r = int'($urandom_range(0, 99));
      if (phase == 0)      sens = sbls_pkg::SENS_W'(1000);
      else if (phase == 1) sens = sbls_pkg::SENS_W'(1);
      else if (r < 15)     sens = {sbls_pkg::SENS_W{1'b1}};
      else if (r < 25)     sens = '0;
      else sens = sbls_pkg::SENS_W'($urandom_range(0, (1 << sbls_pkg::SENS_W) - 1));
      write_sensitivity(sens);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(SAMPLE_W'(pick_sample()));
      drain_block();
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  // Single reset at start (synchronous), then the tests in turn.
  initial begin : run_tests
    foreach (baseline[i]) baseline[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_calibration();
    test_directed();
    test_random();
    drain_block();
    if (error_count == 0) begin
      $display("[spectrum_band_level_scaler] OK");
    end else begin
      $display("[spectrum_band_level_scaler] ERROR");
    end
    $finish;
  end

  // Run-length guard.
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("[spectrum_band_level_scaler] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/sbls_pkg.sv
hdl/sbls_front.sv
hdl/sbls_scale.sv
hdl/sbls_accum.sv
hdl/spectrum_band_level_scaler.sv
tb/sv/spectrum_band_level_scaler_tb.sv
